/* rtl/tmpr_pkg.sv */
`timescale 1ns / 1ps

package tmpr_pkg;

  localparam int MEM_BYTES = 8192;
  localparam int MEM_AW    = 13;

  localparam logic [MEM_AW-1:0] MAP_BASE_LOW  = 13'h1800;
  localparam logic [MEM_AW-1:0] MAP_BASE_HIGH = 13'h1C00;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_MAP   = 2'd1;
  localparam logic [1:0] OP_ATLAS = 2'd2;

  localparam logic [2:0] CFG_PAL0     = 3'd0;
  localparam logic [2:0] CFG_PAL1     = 3'd1;
  localparam logic [2:0] CFG_PAL2     = 3'd2;
  localparam logic [2:0] CFG_PAL3     = 3'd3;
  localparam logic [2:0] CFG_MAP_SEL  = 3'd4;
  localparam logic [2:0] CFG_SIGNED   = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_LO,
    ST_HI,
    ST_OOR
  } state_t;

  typedef enum logic [1:0] {
    ADDR_MAP_Q,
    ADDR_ATLAS_Q,
    ADDR_FROM_MAP,
    ADDR_HI
  } addr_sel_t;

  typedef struct packed {
    logic      wr_en;
    logic      rd_en;
    addr_sel_t addr_sel;
    logic      capture_q;
    logic      capture_lo;
    logic      load_out;
    logic      oor;
  } cmd_t;

  typedef struct packed {
    logic atlas_oor;
  } status_t;

  function automatic logic [31:0] rgba_to_abgr(input logic [31:0] c);
    rgba_to_abgr = {c[7:0], c[15:8], c[23:16], c[31:24]};
  endfunction

endpackage

/* rtl/tmpr_ram.sv */
`timescale 1ns / 1ps

module tmpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/tmpr_ctrl.sv */
`timescale 1ns / 1ps

module tmpr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  output logic               out_valid,
  input  logic               out_ready,
  input  tmpr_pkg::status_t  status,
  output tmpr_pkg::cmd_t     cmd
);
  import tmpr_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_fire;
  logic   out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_opcode)
            OP_MAP:   state_nxt = ST_MAP;
            OP_ATLAS: state_nxt = status.atlas_oor ? ST_OOR : ST_LO;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_MAP:  state_nxt = ST_LO;
      ST_LO:   state_nxt = ST_HI;
      ST_HI:   state_nxt = out_free ? ST_IDLE : ST_HI;
      ST_OOR:  state_nxt = out_free ? ST_IDLE : ST_OOR;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.addr_sel = ADDR_MAP_Q;
    case (state_r)
      ST_IDLE: begin
        cmd.capture_q = in_fire;
        cmd.wr_en     = in_fire && (in_opcode == OP_WRITE);
        if (in_opcode == OP_ATLAS) begin
          cmd.addr_sel = ADDR_ATLAS_Q;
          cmd.rd_en    = in_fire && !status.atlas_oor;
        end else begin
          cmd.rd_en    = in_fire && (in_opcode == OP_MAP);
        end
      end
      ST_MAP: begin
        cmd.addr_sel = ADDR_FROM_MAP;
        cmd.rd_en    = 1'b1;
      end
      ST_LO: begin
        cmd.addr_sel   = ADDR_HI;
        cmd.rd_en      = 1'b1;
        cmd.capture_lo = 1'b1;
      end
      ST_HI: begin
        cmd.load_out = out_free;
      end
      ST_OOR: begin
        cmd.load_out = out_free;
        cmd.oor      = 1'b1;
      end
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result loaded over a pending result");

  a_map_then_lo: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MAP |=> state_r == ST_LO)
    else $error("map fetch not followed by low plane fetch");

  a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_opcode == OP_WRITE) |=> state_r == ST_IDLE)
    else $error("write left idle");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r == ST_HI) || $past(state_r == ST_OOR)))
    else $error("result raised outside a finishing state");

endmodule

/* rtl/tmpr_datapath.sv */
`timescale 1ns / 1ps

module tmpr_datapath #(
  parameter int ATLAS_TILES_PER_ROW = 16,
  parameter int ATLAS_TILE_COUNT    = 384
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic [12:0]       in_mem_address,
  input  logic [7:0]        in_write_byte,
  input  logic [7:0]        in_pixel_x,
  input  logic [7:0]        in_pixel_y,
  output logic [31:0]       out_pixel_color,
  output logic [1:0]        out_color_index,
  output logic              out_out_of_range,
  input  tmpr_pkg::cmd_t    cmd,
  output tmpr_pkg::status_t status
);
  import tmpr_pkg::*;

  localparam logic [10:0] TPR_C   = 11'(ATLAS_TILES_PER_ROW);
  localparam logic [10:0] COUNT_C = 11'(ATLAS_TILE_COUNT);

  logic [31:0] pal_r [4];
  logic        map_sel_r;
  logic        signed_mode_r;

  logic [2:0]        x_r, y_r;
  logic [MEM_AW-1:0] addr_r;
  logic [7:0]        lo_r;
  logic [31:0]       color_r;
  logic [1:0]        index_r;
  logic              oor_r;

  logic [MEM_AW-1:0] rd_addr;
  logic [7:0]        rdata;
  logic [10:0]       atlas_tile;
  logic [8:0]        map_tile;
  logic [2:0]        bit_sel;
  logic [1:0]        pix_index;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pal_r[0]      <= '0;
      pal_r[1]      <= '0;
      pal_r[2]      <= '0;
      pal_r[3]      <= '0;
      map_sel_r     <= 1'b0;
      signed_mode_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PAL0:    pal_r[0]      <= cfg_data;
        CFG_PAL1:    pal_r[1]      <= cfg_data;
        CFG_PAL2:    pal_r[2]      <= cfg_data;
        CFG_PAL3:    pal_r[3]      <= cfg_data;
        CFG_MAP_SEL: map_sel_r     <= cfg_data[0];
        CFG_SIGNED:  signed_mode_r <= cfg_data[0];
        default:     ;
      endcase
    end
  end

  assign atlas_tile = {6'd0, in_pixel_y[7:3]} * TPR_C + {6'd0, in_pixel_x[7:3]};
  assign status.atlas_oor = ({6'd0, in_pixel_x[7:3]} >= TPR_C) || (atlas_tile >= COUNT_C);

  // signed mode: 256 + signed byte, so bit 8 is the inverted sign
  assign map_tile = {signed_mode_r & ~rdata[7], rdata};

  always_comb begin
    case (cmd.addr_sel)
      ADDR_MAP_Q:
        rd_addr = (map_sel_r ? MAP_BASE_HIGH : MAP_BASE_LOW)
                | {3'd0, in_pixel_y[7:3], in_pixel_x[7:3]};
      ADDR_ATLAS_Q:  rd_addr = {atlas_tile[8:0], in_pixel_y[2:0], 1'b0};
      ADDR_FROM_MAP: rd_addr = {map_tile, y_r, 1'b0};
      ADDR_HI:       rd_addr = {addr_r[MEM_AW-1:1], 1'b1};
      default:       rd_addr = addr_r;
    endcase
  end

  tmpr_ram #(
    .WIDTH (8),
    .DEPTH (MEM_BYTES)
  ) u_vram (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (in_mem_address),
    .wdata (in_write_byte),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture_q) begin
      x_r <= in_pixel_x[2:0];
      y_r <= in_pixel_y[2:0];
    end
    if (cmd.rd_en) begin
      addr_r <= rd_addr;
    end
    if (cmd.capture_lo) begin
      lo_r <= rdata;
    end
  end

  // high plane byte sits on the RAM output while in the last fetch state
  assign bit_sel   = 3'd7 - x_r;
  assign pix_index = {rdata[bit_sel], lo_r[bit_sel]};

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (cmd.oor) begin
        color_r <= '0;
        index_r <= '0;
        oor_r   <= 1'b1;
      end else begin
        color_r <= rgba_to_abgr(pal_r[pix_index]);
        index_r <= pix_index;
        oor_r   <= 1'b0;
      end
    end
  end

  assign out_pixel_color  = color_r;
  assign out_color_index  = index_r;
  assign out_out_of_range = oor_r;

endmodule

/* rtl/tile_map_pixel_renderer.sv */
`timescale 1ns / 1ps

// Background tile renderer with an 8 KiB video memory.
// Input channel (in_valid/in_ready) carries one item per transfer: opcode 0
// writes in_write_byte at in_mem_address, opcode 1 looks up pixel
// (in_pixel_x, in_pixel_y) on the 32x32 tile map, opcode 2 looks up the
// pixel in the tile atlas. Opcode 3 is dropped. Writes give no result.
// Each query gives one result on the output channel (out_valid/out_ready):
// ABGR colour, 2-bit colour index and an out-of-range flag for atlas pixels
// outside the atlas.
// One item at a time: a map query fetches map entry, low plane and high
// plane in turn through the single read port of the video memory, an atlas
// query only the two planes, and an out-of-range one nothing. The result
// register is loaded once the high plane byte is on the RAM output.
// A stalled receiver holds the result register; the block then waits in its
// last state and takes no new item until the result is taken.
// Synchronous reset clears control state and the configuration registers;
// video memory is not cleared and must be written before it is read.
// The user writes configuration (cfg_we/cfg_index/cfg_data) only while
// idle; the block itself does not enforce this.
module tile_map_pixel_renderer #(
  parameter int ATLAS_TILES_PER_ROW = 16,
  parameter int ATLAS_TILE_COUNT    = 384
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [12:0] in_mem_address,
  input  logic [7:0]  in_write_byte,
  input  logic [7:0]  in_pixel_x,
  input  logic [7:0]  in_pixel_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_pixel_color,
  output logic [1:0]  out_color_index,
  output logic        out_out_of_range
);
  import tmpr_pkg::*;

  cmd_t    cmd;
  status_t status;

  tmpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  tmpr_datapath #(
    .ATLAS_TILES_PER_ROW (ATLAS_TILES_PER_ROW),
    .ATLAS_TILE_COUNT    (ATLAS_TILE_COUNT)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_mem_address   (in_mem_address),
    .in_write_byte    (in_write_byte),
    .in_pixel_x       (in_pixel_x),
    .in_pixel_y       (in_pixel_y),
    .out_pixel_color  (out_pixel_color),
    .out_color_index  (out_color_index),
    .out_out_of_range (out_out_of_range),
    .cmd              (cmd),
    .status           (status)
  );

endmodule
